### hdl/md2_pkg.sv
// md2_pkg: shared constants, the substitution table, FSM states and
// control structs for the MD2 hash engine.
// No dependencies.
package md2_pkg;

	localparam int Rounds     = 18;
	localparam int BlockBytes = 16;
	localparam int StateBytes = 48;

	// Fixed MD2 substitution table (derived from the digits of pi)
	localparam logic [7:0] SBOX [256] = '{
		8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
		8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
		8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
		8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
		8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
		8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
		8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
		8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
		8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
		8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
		8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
		8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
		8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
		8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
		8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
		8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
		8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
		8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
		8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
		8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
		8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
		8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
		8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
		8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
		8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
		8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
		8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
		8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
		8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
		8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
		8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
		8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
	};

	function automatic logic [7:0] md2_sbox(input logic [7:0] a);
		return SBOX[a];
	endfunction

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_SETUP,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Block buffer control: load shifts din in at the tail, rotate recirculates
	typedef struct packed {
		logic       load;
		logic       rotate;
		logic [7:0] din;
	} buf_ctl_t;

	// Checksum ring control
	typedef struct packed {
		logic update;
		logic rotate;
		logic clear;
	} chk_ctl_t;

	// Chain state ring control
	typedef struct packed {
		logic       setup;
		logic       round;
		logic       round_end;
		logic [4:0] round_idx;
		logic       clear;
	} cmp_ctl_t;

endpackage

### hdl/md2_buf.sv
// md2_buf: 16-byte block buffer as a byte-wide shift register.
// Depends on md2_pkg.
module md2_buf (
	input  logic              clk,
	input  md2_pkg::buf_ctl_t ctl,
	output logic [7:0]        head
);
	import md2_pkg::*;

	logic [7:0] blk_q [BlockBytes];

	// Bytes enter at the tail; after a full block, entry 0 is the first byte
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.rotate) begin
			for (int i = 0; i < BlockBytes - 1; i++) begin
				blk_q[i] <= blk_q[i + 1];
			end
			blk_q[BlockBytes - 1] <= ctl.load ? ctl.din : blk_q[0];
		end
	end

	assign head = blk_q[0];

endmodule

### hdl/md2_chk.sv
// md2_chk: 16-byte running checksum ring, a byte a cycle on update or rotate.
// Depends on md2_pkg (substitution table, control struct).
module md2_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  md2_pkg::chk_ctl_t ctl,
	input  logic [7:0]        blk_byte,
	output logic [7:0]        head
);
	import md2_pkg::*;

	logic [7:0] cs_q [BlockBytes];
	logic [7:0] cs_new;

	// The tail always holds the previously updated byte ("last")
	assign cs_new = cs_q[0] ^ md2_sbox(blk_byte ^ cs_q[BlockBytes - 1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BlockBytes; i++) cs_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < BlockBytes; i++) cs_q[i] <= '0;
		end else if (ctl.update || ctl.rotate) begin
			for (int i = 0; i < BlockBytes - 1; i++) begin
				cs_q[i] <= cs_q[i + 1];
			end
			cs_q[BlockBytes - 1] <= ctl.update ? cs_new : cs_q[0];
		end
	end

	assign head = cs_q[0];

endmodule

### hdl/md2_cmp.sv
// md2_cmp: 48-byte chain state ring and the byte-serial compression step.
// Depends on md2_pkg (substitution table, control struct).
module md2_cmp (
	input  logic              clk,
	input  logic              arst_n,
	input  md2_pkg::cmp_ctl_t ctl,
	input  logic [7:0]        blk_byte,
	output logic [63:0]       digest_high,
	output logic [63:0]       digest_low
);
	import md2_pkg::*;

	localparam int LaneA = BlockBytes - 1;
	localparam int LaneB = 2 * BlockBytes - 1;
	localparam int LaneC = StateBytes - 1;

	logic [7:0] st_q [StateBytes];
	logic [7:0] t_q;
	logic [7:0] nb;

	// One round step: head byte xor sbox[t]
	assign nb = st_q[0] ^ md2_sbox(t_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < StateBytes; i++) st_q[i] <= '0;
			t_q <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < StateBytes; i++) st_q[i] <= '0;
			t_q <= '0;
		end else if (ctl.setup) begin
			// three 16-byte lanes shift side by side: lane A rotates, lane B takes blk_byte, lane C blk_byte xor head
			for (int i = 0; i < LaneA; i++) begin
				st_q[i] <= st_q[i + 1];
			end
			st_q[LaneA] <= st_q[0];
			for (int i = LaneA + 1; i < LaneB; i++) begin
				st_q[i] <= st_q[i + 1];
			end
			st_q[LaneB] <= blk_byte;
			for (int i = LaneB + 1; i < LaneC; i++) begin
				st_q[i] <= st_q[i + 1];
			end
			st_q[LaneC] <= blk_byte ^ st_q[0];
			t_q         <= '0;
		end else if (ctl.round) begin
			// whole 48-byte ring rotates, processed byte goes to the tail
			for (int i = 0; i < StateBytes - 1; i++) begin
				st_q[i] <= st_q[i + 1];
			end
			st_q[LaneC] <= nb;
			t_q         <= ctl.round_end ? nb + {3'b000, ctl.round_idx} : nb;
		end
	end

	// Digest is bytes 0 to 15, first byte most significant
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			digest_high[63 - 8 * k -: 8] = st_q[k];
			digest_low[63 - 8 * k -: 8]  = st_q[k + 8];
		end
	end

endmodule

### hdl/md2_hash_engine_top.sv
// md2_hash_engine_top: MD2 digest engine, stream in, digest out.
// Depends on md2_pkg, md2_buf, md2_chk, md2_cmp.
//
//   channel  dir  tdata                            tuser           tlast
//   s_*      in   [7:0] data_byte                  byte_present    end_of_message
//   m_*      out  [63:0] digest_high,              -               -
//                 [127:64] digest_low
//
// Message bytes are taken while idle. Each full 16-byte block then goes through the
// byte-serial compression ring: a setup pass plus 18 rounds of 48 sbox steps.
// Finalization: 1 to 16 pad bytes, the padded block (plus one more compression when the
// end byte completed a block), the checksum block, then the load once the output is free.
// Reset clears chain state, checksum and counters at once; there is no clearing pass.
// The digest sits in an output register; the next message is taken while it waits.
module md2_hash_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] byte_present
	input  logic         s_tlast,   // end_of_message
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // [63:0] digest_high, [127:64] digest_low
);
	import md2_pkg::*;

	localparam logic [3:0] LastIdx  = 4'(BlockBytes - 1);
	localparam logic [5:0] LastByte = 6'(StateBytes - 1);
	localparam logic [4:0] LastRnd  = 5'(Rounds - 1);
	localparam logic [4:0] FullPad  = 5'(BlockBytes);

	state_t      state_q, state_d;
	logic [3:0]  cnt_q;
	logic [3:0]  sidx_q;
	logic [5:0]  byte_q;
	logic [4:0]  round_q;
	logic [4:0]  pad_q;
	logic        fin_q, padded_q, cs_blk_q;
	logic        out_valid_q;
	logic [127:0] digest_q;

	logic        in_xfer, out_xfer, comp_end, load_out;
	buf_ctl_t    buf_ctl;
	chk_ctl_t    chk_ctl;
	cmp_ctl_t    cmp_ctl;
	logic [7:0]  buf_head, chk_head, blk_byte;
	logic [63:0] dig_hi, dig_lo;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign comp_end = (round_q == LastRnd) && (byte_q == LastByte);
	assign load_out = (state_q == ST_DONE) && !out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (s_tuser && cnt_q == LastIdx) state_d = ST_SETUP;
					else if (s_tlast)                state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (cnt_q == LastIdx) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (sidx_q == LastIdx) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (comp_end) begin
					if (cs_blk_q)              state_d = ST_DONE;
					else if (fin_q && padded_q) state_d = ST_SETUP;
					else if (fin_q)             state_d = ST_PAD;
					else                        state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		buf_ctl.load    = ((state_q == ST_IDLE) && in_xfer && s_tuser) || (state_q == ST_PAD);
		buf_ctl.rotate  = (state_q == ST_SETUP) && !cs_blk_q;
		buf_ctl.din     = (state_q == ST_PAD) ? {3'b000, pad_q} : s_tdata;
		chk_ctl.update  = (state_q == ST_SETUP) && !cs_blk_q;
		chk_ctl.rotate  = (state_q == ST_SETUP) && cs_blk_q;
		chk_ctl.clear   = load_out;
		cmp_ctl.setup   = (state_q == ST_SETUP);
		cmp_ctl.round   = (state_q == ST_ROUND);
		cmp_ctl.round_end = (byte_q == LastByte);
		cmp_ctl.round_idx = round_q;
		cmp_ctl.clear   = load_out;
	end

	assign blk_byte = cs_blk_q ? chk_head : buf_head;

	// State, counters and message flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sidx_q   <= '0;
			byte_q   <= '0;
			round_q  <= '0;
			pad_q    <= '0;
			fin_q    <= 1'b0;
			padded_q <= 1'b0;
			cs_blk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tuser) cnt_q <= cnt_q + 4'd1;
						if (s_tlast) begin
							fin_q <= 1'b1;
							pad_q <= FullPad - {1'b0, cnt_q} - {4'b0000, s_tuser};
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LastIdx) padded_q <= 1'b1;
				end
				ST_SETUP: begin
					sidx_q <= sidx_q + 4'd1;
				end
				ST_ROUND: begin
					if (byte_q == LastByte) begin
						byte_q  <= '0;
						round_q <= comp_end ? 5'd0 : round_q + 5'd1;
					end else begin
						byte_q <= byte_q + 6'd1;
					end
					if (comp_end && !cs_blk_q && fin_q) begin
						if (padded_q) cs_blk_q <= 1'b1;
						else          pad_q    <= FullPad;
					end
				end
				ST_DONE: begin
					if (!out_valid_q) begin
						cnt_q    <= '0;
						fin_q    <= 1'b0;
						padded_q <= 1'b0;
						cs_blk_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) digest_q <= {dig_lo, dig_hi};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = digest_q;

	md2_buf u_buf (
		.clk  (clk),
		.ctl  (buf_ctl),
		.head (buf_head)
	);

	md2_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (chk_ctl),
		.blk_byte (blk_byte),
		.head     (chk_head)
	);

	md2_cmp u_cmp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (cmp_ctl),
		.blk_byte    (blk_byte),
		.digest_high (dig_hi),
		.digest_low  (dig_lo)
	);

`ifndef SYNTHESIS
	// An end marker always starts finalization, so input stalls next cycle
	a_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input not stalled after end of message");

	// Loading the output register always raises valid
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("digest load did not raise valid");

	// Round and byte counters stay in range during compression
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q <= LastRnd) && (byte_q <= LastByte))
		else $error("compression counter out of range");

	// Checksum block is compressed only after a padded block
	a_cs_order: assert property (@(posedge clk) disable iff (!arst_n)
		cs_blk_q |-> (fin_q && padded_q))
		else $error("checksum block without padding");
`endif

endmodule

### tb/tb_md2_hash_engine_top.sv
// tb_md2_hash_engine_top: self-checking bench for the MD2 digest engine; a directed
// table then random messages, digests checked by a local MD2 predictor or typed value.
// Depends on md2_pkg and md2_hash_engine_top.
`timescale 1ns / 1ps

module tb_md2_hash_engine_top;
	import md2_pkg::*;

	localparam int NumItems    = 1300;
	localparam int FinalCycles = 2700;  // pad + up to three compressions + load
	localparam int MaxGap      = 60;
	localparam int MaxStall    = 400;
	localparam int HoldCycles  = 8000;  // long receiver hold-off, spans several messages
	localparam int CycleLimit  = (NumItems + 300) * (FinalCycles + MaxGap + MaxStall) * 3
		+ HoldCycles;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
	} digest_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
		logic       typed;
		digest_t    digest;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;   // [7:0] data_byte
	logic         s_tuser = 1'b0;    // [0] byte_present
	logic         s_tlast = 1'b0;    // end_of_message
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;           // [63:0] digest_high, [127:64] digest_low

	// Predictor state
	logic [7:0]   pred_chain [StateBytes];
	logic [7:0]   pred_sum [BlockBytes];
	logic [127:0] pred_blk;
	int           pred_fill;

	digest_t      pending_digests [$];
	stim_row_t    dir_rows [$];
	int           fail_count = 0;
	int           cycles = 0;
	int           items_done = 0;
	int           msg_count = 0;
	int           byte_count = 0;
	int           idle_count = 0;
	int           cur_len = 0;
	int           longest = 0;
	int           digests_seen = 0;
	bit           hold_request = 0;

	md2_hash_engine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------- MD2 predictor ----------------

	task automatic clear_digest_state();
		for (int i = 0; i < StateBytes; i++)
			pred_chain[i] = 8'h00;
		for (int i = 0; i < BlockBytes; i++)
			pred_sum[i] = 8'h00;
		pred_blk  = '0;
		pred_fill = 0;
	endtask

	// 18-round compression of one block into the chain state
	task automatic mix_block(input logic [127:0] blk);
		logic [7:0] t;
		t = 8'h00;
		for (int i = 0; i < BlockBytes; i++) begin
			pred_chain[16 + i] = blk[8*i +: 8];
			pred_chain[32 + i] = blk[8*i +: 8] ^ pred_chain[i];
		end
		for (int r = 0; r < Rounds; r++) begin
			for (int i = 0; i < StateBytes; i++) begin
				pred_chain[i] = pred_chain[i] ^ SBOX[t];
				t = pred_chain[i];
			end
			t = t + r[7:0];
		end
	endtask

	task automatic fold_checksum(input logic [127:0] blk);
		logic [7:0] prev;
		prev = pred_sum[BlockBytes - 1];
		for (int i = 0; i < BlockBytes; i++) begin
			pred_sum[i] = pred_sum[i] ^ SBOX[blk[8*i +: 8] ^ prev];
			prev = pred_sum[i];
		end
	endtask

	// One accepted transfer; made is set when a digest results
	task automatic predict_digest(input logic [7:0] data, input logic present,
		input logic eom, output bit made, output digest_t d);
		logic [127:0] sum_blk;
		logic [7:0]   pad;
		made = 0;
		d = '0;
		if (present) begin
			pred_blk[8*pred_fill +: 8] = data;
			pred_fill++;
			if (pred_fill == BlockBytes) begin
				fold_checksum(pred_blk);
				mix_block(pred_blk);
				pred_fill = 0;
			end
		end
		if (eom) begin
			pad = 8'(BlockBytes - pred_fill);
			for (int i = pred_fill; i < BlockBytes; i++)
				pred_blk[8*i +: 8] = pad;
			fold_checksum(pred_blk);
			mix_block(pred_blk);
			for (int i = 0; i < BlockBytes; i++)
				sum_blk[8*i +: 8] = pred_sum[i];
			mix_block(sum_blk);
			for (int i = 0; i < 8; i++) begin
				d.high = {d.high[55:0], pred_chain[i]};
				d.low  = {d.low[55:0], pred_chain[8 + i]};
			end
			made = 1;
			clear_digest_state();
		end
	endtask

	// ---------------- Stimulus ----------------

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, MaxGap);
	endfunction

	function automatic logic [7:0] pick_byte(input bit extremes);
		int r;
		r = $urandom_range(0, 3);
		if (extremes && r == 0)
			return 8'h00;
		if (extremes && r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_row(input logic [7:0] data, input logic present, input logic eom,
		input logic typed, input digest_t d);
		stim_row_t row;
		row.data    = data;
		row.present = present;
		row.eom     = eom;
		row.typed   = typed;
		row.digest  = d;
		dir_rows.push_back(row);
	endtask

	// Offer one transfer, wait for acceptance, then maybe idle; called at a rising edge
	task automatic offer_item(input logic [7:0] data, input logic present, input logic eom,
		input logic typed, input digest_t typed_val, input bit quiet);
		digest_t d;
		bit      made;
		int      gap;
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_digest(data, present, eom, made, d);
		if (made) begin
			if (typed)
				d = typed_val;
			pending_digests.push_back(d);
		end
		if (present) begin
			byte_count++;
			cur_len++;
		end
		if (eom) begin
			msg_count++;
			if (cur_len > longest)
				longest = cur_len;
			cur_len = 0;
		end
		if (present || eom)
			items_done++;
		else
			idle_count++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		digest_t empty_digest;
		digest_t none;
		int      len;
		int      r;
		bit      bare_end;
		bit      quiet;
		bit      extremes;
		logic    eom;

		none = '0;
		empty_digest.high = 64'h8350e5a3e24c153d;
		empty_digest.low  = 64'hf2275c9f80692773;
		clear_digest_state();

		// Directed table: empty message, single extreme bytes, ignored idle items,
		// a bare end marker after bytes, and a full block ending on the end byte
		add_row(8'h00, 1'b0, 1'b1, 1'b1, empty_digest);
		add_row(8'h00, 1'b1, 1'b1, 1'b0, none);
		add_row(8'hFF, 1'b1, 1'b1, 1'b0, none);
		add_row(8'hA5, 1'b0, 1'b0, 1'b0, none);
		add_row(8'h61, 1'b1, 1'b0, 1'b0, none);
		add_row(8'hFF, 1'b0, 1'b0, 1'b0, none);
		add_row(8'h62, 1'b1, 1'b0, 1'b0, none);
		add_row(8'h63, 1'b1, 1'b0, 1'b0, none);
		add_row(8'hFF, 1'b0, 1'b1, 1'b0, none);
		for (int i = 0; i < BlockBytes; i++)
			add_row((i % 2) ? 8'h00 : 8'hFF, 1'b1, i == BlockBytes - 1, 1'b0, none);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer_item(dir_rows[i].data, dir_rows[i].present, dir_rows[i].eom,
				dir_rows[i].typed, dir_rows[i].digest, 1'b0);

		// Random messages; the receiver takes one long hold-off early on
		hold_request = 1;
		while (items_done < NumItems) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 25)
				len = $urandom_range(0, 1) ? $urandom_range(14, 18) : $urandom_range(31, 33);
			else if (r < 88)
				len = $urandom_range(1, 40);
			else
				len = $urandom_range(41, 120);
			bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
			quiet    = ($urandom_range(0, 3) == 0);
			extremes = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 19) == 0)
					offer_item(pick_byte(1'b0), 1'b0, 1'b0, 1'b0, none, quiet);
				eom = !bare_end && (k == len - 1);
				offer_item(pick_byte(extremes), 1'b1, eom, 1'b0, none, quiet);
			end
			if (bare_end)
				offer_item(pick_byte(1'b0), 1'b0, 1'b1, 1'b0, none, quiet);
		end
		s_tvalid <= 1'b0;

		// Drain, then watch for stray digests
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (FinalCycles) @(posedge clk);

		$display("Run covered %0d messages, %0d bytes (longest %0d), %0d idle transfers.",
			msg_count, byte_count, longest, idle_count);
		$display("%0d digests compared; receiver hold-off of %0d cycles applied once.",
			digests_seen, HoldCycles);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// ---------------- Receiver pacing ----------------

	initial begin : rx_pacing
		int stall;
		int r;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(500, 3000)) @(posedge clk);
			else
				repeat ($urandom_range(1, 30)) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 70)
				stall = $urandom_range(1, 3);
			else if (r < 95)
				stall = $urandom_range(4, 15);
			else
				stall = $urandom_range(100, MaxStall);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// ---------------- Digest check ----------------

	always @(posedge clk) begin
		digest_t d;
		if (arst_n && m_tvalid && m_tready) begin
			digests_seen++;
			if (pending_digests.size() == 0) begin
				$error("digest transfer with no expectation: %h", m_tdata);
				fail_count++;
			end else begin
				d = pending_digests.pop_front();
				if (m_tdata[63:0] !== d.high) begin
					$error("digest_high: expected %h, got %h", d.high, m_tdata[63:0]);
					fail_count++;
				end
				if (m_tdata[127:64] !== d.low) begin
					$error("digest_low: expected %h, got %h", d.low, m_tdata[127:64]);
					fail_count++;
				end
			end
		end
	end

endmodule

### md2_hash_engine_top.f
hdl/md2_pkg.sv
hdl/md2_buf.sv
hdl/md2_chk.sv
hdl/md2_cmp.sv
hdl/md2_hash_engine_top.sv
tb/tb_md2_hash_engine_top.sv
